FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: rtl/core/wlm_pkg.sv
// ----------------------------------------------------------------------------
// wlm_pkg
// Types and constants for the windowed latency monitor.
// ----------------------------------------------------------------------------
`default_nettype none
package wlm_pkg;
	localparam int IdCount   = 256;
	localparam int IdBits    = 8;
	localparam int TimeBits  = 32;
	localparam int EntryBits = TimeBits + 1;
	localparam int SumBits   = TimeBits + IdBits + 1;
	localparam int CntBits   = IdBits + 1;
	localparam int QBits     = SumBits + 8;
	localparam logic [31:0] PeriodReset = 32'd1000;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_ARRIVAL  = 2'd1,
		OP_ANSWERED = 2'd2,
		OP_FINISHED = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] call_id;
	} in_item_t;

	typedef struct packed {
		logic [39:0] avg_answered;
		logic [31:0] max_answered;
		logic [39:0] avg_finished;
		logic [31:0] max_finished;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EVENT, ST_CLEAR, ST_RD, ST_ACC, ST_DIV_A, ST_WAIT_A,
		ST_DIV_F, ST_WAIT_F, ST_EMIT
	} state_t;

	typedef struct packed {
		logic       ev_write;
		logic       tick;
		logic       idx_clr;
		logic       idx_inc;
		logic       rd;
		logic       acc;
		logic       acc_clr;
		logic       div_start;
		logic       div_sel_f;
		logic       save_a;
		logic       clear_valid;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic report;
		logic idx_last;
		logic div_done;
	} sts_t;
endpackage
`default_nettype wire

FILE: rtl/core/windowed_latency_monitor.sv
// ----------------------------------------------------------------------------
// windowed_latency_monitor
// Periodic average/maximum latency report over per-id event stamps.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake         Payload
// item      in         start / busy      in_item_t
// result    out        result_valid      out_item_t
// cfg       in         cfg_valid/ready   report_period
//
// An event writes its time stamp; a non-reporting tick only advances time.
// A reporting tick also walks every id (read, then accumulate and wipe the
// entry), then runs the answered and finished divides and emits the result.
// Reset clears time and period counter, then a pass over every id wipes the
// stamp tables with busy high.
// result_valid holds one cycle; the receiver cannot stall.
`default_nettype none
module windowed_latency_monitor import wlm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire in_item_t    item,
	output out_item_t        result,
	output logic             result_valid,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;

	wlm_ctrl u_ctrl (.clk, .arst_n, .start, .op(op_t'(item.operation)), .sts, .cmd, .busy);
	wlm_datapath u_dp (.clk, .arst_n, .cmd, .sts, .item, .cfg_valid, .cfg_data,
		.cfg_ready, .result, .result_valid);
endmodule
`default_nettype wire

FILE: rtl/core/wlm_ram.sv
// ----------------------------------------------------------------------------
// wlm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module wlm_ram #(
	parameter int Width = 32,
	parameter int Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/wlm_div.sv
// ----------------------------------------------------------------------------
// wlm_div
// Restoring divider, one quotient bit per cycle: (sum << 8) / count.
// ----------------------------------------------------------------------------
`default_nettype none
module wlm_div import wlm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SumBits-1:0] sum,
	input  wire logic [CntBits-1:0] count,
	output logic                    done,
	output logic [39:0]             avg
);
	localparam int CW = $clog2(QBits + 1);
	logic [QBits-1:0]   num_q;
	logic [CntBits:0]   rem_q;
	logic [CntBits-1:0] den_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic [CntBits:0]   trial;
	logic [CntBits:0]   diff;

	assign trial = {rem_q[CntBits-1:0], num_q[QBits-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {sum, 8'd0};
			rem_q <= '0;
			den_q <= count;
		end else if (busy_q) begin
			if (!diff[CntBits]) begin
				rem_q <= diff;
				num_q <= {num_q[QBits-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[QBits-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (den_q == '0) avg = '0;
		else if (|num_q[QBits-1:40]) avg = '1;
		else avg = num_q[39:0];
	end
endmodule
`default_nettype wire

FILE: rtl/core/wlm_datapath.sv
// ----------------------------------------------------------------------------
// wlm_datapath
// Time base, stamp tables, valid marks, accumulators and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module wlm_datapath import wlm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cmd_t     cmd,
	output sts_t          sts,
	input  wire in_item_t item,
	input  wire logic     cfg_valid,
	input  wire logic [31:0] cfg_data,
	output logic          cfg_ready,
	output out_item_t     result,
	output logic          result_valid
);
	logic [TimeBits-1:0]  now_q;
	logic [31:0]          elapsed_q, period_q;
	in_item_t             item_q;
	logic [IdBits-1:0]    idx_q, idx_s1;
	logic                 arr_vs, ans_vs, fin_vs;
	logic [EntryBits-1:0] arr_rd, ans_rd, fin_rd, wdata;
	logic [SumBits-1:0]   sum_a_q, sum_f_q;
	logic [CntBits-1:0]   cnt_a_q, cnt_f_q;
	logic [TimeBits-1:0]  max_a_q, max_f_q, base, lat_a, lat_f;
	logic [39:0]          avg_a_q, div_avg;
	logic                 div_done;
	logic [IdBits-1:0]    addr;
	logic                 we_arr, we_ans, we_fin;
	logic [31:0]          elapsed_nx;

	assign cfg_ready = 1'b1;
	assign addr = cmd.ev_write ? item_q.call_id : (cmd.acc ? idx_s1 : idx_q);
	assign wdata = cmd.clear_valid ? '0 : {1'b1, now_q};
	assign we_arr = cmd.clear_valid || (cmd.ev_write && item_q.operation == OP_ARRIVAL);
	assign we_ans = cmd.clear_valid || (cmd.ev_write && item_q.operation == OP_ANSWERED);
	assign we_fin = cmd.clear_valid || (cmd.ev_write && item_q.operation == OP_FINISHED);

	wlm_ram #(.Width(EntryBits), .Depth(IdCount)) u_arr (.clk, .we(we_arr), .addr,
		.wdata, .rdata(arr_rd));
	wlm_ram #(.Width(EntryBits), .Depth(IdCount)) u_ans (.clk, .we(we_ans), .addr,
		.wdata, .rdata(ans_rd));
	wlm_ram #(.Width(EntryBits), .Depth(IdCount)) u_fin (.clk, .we(we_fin), .addr,
		.wdata, .rdata(fin_rd));

	wlm_div u_div (.clk, .arst_n, .start(cmd.div_start),
		.sum(cmd.div_sel_f ? sum_f_q : sum_a_q),
		.count(cmd.div_sel_f ? cnt_f_q : cnt_a_q), .done(div_done), .avg(div_avg));

	assign elapsed_nx = elapsed_q + 32'd1;
	assign arr_vs = arr_rd[TimeBits];
	assign ans_vs = ans_rd[TimeBits];
	assign fin_vs = fin_rd[TimeBits];
	assign base  = arr_vs ? arr_rd[TimeBits-1:0] : '0;
	assign lat_a = ans_rd[TimeBits-1:0] - base;
	assign lat_f = fin_rd[TimeBits-1:0] - base;
	assign sts.report   = elapsed_nx >= period_q;
	assign sts.idx_last = idx_q == IdBits'(IdCount - 1);
	assign sts.div_done = div_done;

	always_ff @(posedge clk) begin
		item_q <= item;
		idx_s1 <= idx_q;
		if (cmd.save_a) avg_a_q <= div_avg;
		if (cmd.emit) begin
			result.avg_answered <= avg_a_q;
			result.max_answered <= max_a_q;
			result.avg_finished <= div_avg;
			result.max_finished <= max_f_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0; elapsed_q <= '0; period_q <= PeriodReset;
			idx_q <= '0; result_valid <= 1'b0;
			sum_a_q <= '0; sum_f_q <= '0; cnt_a_q <= '0; cnt_f_q <= '0;
			max_a_q <= '0; max_f_q <= '0;
		end else begin
			result_valid <= cmd.emit;
			if (cfg_valid) period_q <= cfg_data;
			if (cmd.tick) begin
				now_q <= now_q + 1'b1;
				elapsed_q <= sts.report ? '0 : elapsed_nx;
			end
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.acc_clr) begin
				sum_a_q <= '0; sum_f_q <= '0; cnt_a_q <= '0; cnt_f_q <= '0;
				max_a_q <= '0; max_f_q <= '0;
			end else if (cmd.acc) begin
				if (ans_vs) begin
					sum_a_q <= sum_a_q + SumBits'(lat_a);
					cnt_a_q <= cnt_a_q + 1'b1;
					if (lat_a > max_a_q) max_a_q <= lat_a;
				end
				if (fin_vs) begin
					sum_f_q <= sum_f_q + SumBits'(lat_f);
					cnt_f_q <= cnt_f_q + 1'b1;
					if (lat_f > max_f_q) max_f_q <= lat_f;
				end
			end
		end
	end

	`include "assert_macros.svh"
	`ASSERT_NEVER(a_emit_no_tick, clk, arst_n, cmd.emit && cmd.tick)
	`ASSERT_IMPL(a_cnt_bound, clk, arst_n, cnt_a_q <= CntBits'(IdCount))
	`ASSERT_IMPL(a_emit_valid, clk, arst_n, cmd.emit |=> result_valid)
	`ASSERT_IMPL(a_walk_addr, clk, arst_n, cmd.acc |-> idx_q == idx_s1 + 1'b1)
endmodule
`default_nettype wire

FILE: rtl/core/wlm_ctrl.sv
// ----------------------------------------------------------------------------
// wlm_ctrl
// Controller: table clearing, event write, tick, table walk, two divides, emit.
// ----------------------------------------------------------------------------
`default_nettype none
module wlm_ctrl import wlm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire op_t  op,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      busy
);
	state_t state_q, state_nx;
	logic   walking_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			walking_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_RD) walking_q <= !sts.idx_last;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (op != OP_TICK) state_nx = ST_EVENT;
					else if (sts.report) state_nx = ST_RD;
				end
			end
			ST_EVENT:  state_nx = ST_IDLE;
			ST_RD:     state_nx = ST_ACC;
			ST_ACC:    state_nx = walking_q ? ST_RD : ST_DIV_A;
			ST_DIV_A:  state_nx = ST_WAIT_A;
			ST_WAIT_A: if (sts.div_done) state_nx = ST_DIV_F;
			ST_DIV_F:  state_nx = ST_WAIT_F;
			ST_WAIT_F: if (sts.div_done) state_nx = ST_EMIT;
			ST_EMIT:   state_nx = ST_IDLE;
			ST_CLEAR:  if (sts.idx_last) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = state_q != ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				cmd.tick = start && op == OP_TICK;
				cmd.idx_clr = 1'b1;
				cmd.acc_clr = 1'b1;
			end
			ST_EVENT:  cmd.ev_write = 1'b1;
			ST_RD: begin
				cmd.rd = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				cmd.clear_valid = 1'b1;
			end
			ST_DIV_A:  cmd.div_start = 1'b1;
			ST_WAIT_A: cmd.save_a = 1'b1;
			ST_DIV_F: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_f = 1'b1;
			end
			ST_WAIT_F: begin
				cmd.div_sel_f = 1'b1;
				cmd.emit = sts.div_done;
			end
			ST_EMIT:   cmd.div_sel_f = 1'b1;
			ST_CLEAR: begin
				cmd.clear_valid = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			default:   cmd = '0;
		endcase
	end

	`include "assert_macros.svh"
	`ASSERT_IMPL(a_busy_event, clk, arst_n, state_q == ST_EVENT |=> state_q == ST_IDLE)
	`ASSERT_IMPL(a_emit_idle, clk, arst_n, cmd.emit |=> ##1 state_q == ST_IDLE)
	`ASSERT_NEVER(a_start_walk, clk, arst_n, cmd.tick && busy)
endmodule
`default_nettype wire
